FILE: rtl/tcpq_pkg.sv
package tcpq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int ID_BITS_DEF  = 16;

	localparam int FUNC_W = 3;

	localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SERVE    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_WITHDRAW = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_SIZE     = 3'd4;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic insert;    // place the key at the class boundary, shift tail right
		logic remove;    // drop the hit entry, shift tail left
		logic serve;     // removal starts at the head
		logic ins_pref;  // class of the key being inserted
	} tcpq_ctl_t;

endpackage

FILE: rtl/tcpq_cell.sv
module tcpq_cell
	import tcpq_pkg::*;
#(
	parameter int ID_BITS = ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcpq_ctl_t          ctl,
	input  logic [ID_BITS-1:0] key,
	input  logic [ID_BITS-1:0] left_id,
	input  logic               left_pref,
	input  logic               left_valid,
	input  logic               left_bound,
	input  logic [ID_BITS-1:0] right_id,
	input  logic               right_pref,
	input  logic               right_valid,
	input  logic               hit_in,
	output logic [ID_BITS-1:0] cell_id,
	output logic               cell_pref,
	output logic               cell_valid,
	output logic               bound,
	output logic               hit_out,
	output logic               match
);

	logic [ID_BITS-1:0] id_q;
	logic               pref_q;
	logic               valid_q;
	logic [ID_BITS-1:0] id_d;
	logic               pref_d;
	logic               valid_d;

	assign match   = valid_q && (id_q == key);
	// first cell where bound is set is the insert position
	assign bound   = !valid_q || (ctl.ins_pref && !pref_q);
	assign hit_out = hit_in || match;

	always_comb begin
		id_d    = id_q;
		pref_d  = pref_q;
		valid_d = valid_q;
		if (ctl.insert) begin
			if (bound && !left_bound) begin
				id_d    = key;
				pref_d  = ctl.ins_pref;
				valid_d = 1'b1;
			end else if (bound) begin
				id_d    = left_id;
				pref_d  = left_pref;
				valid_d = left_valid;
			end
		end else if (ctl.remove && hit_out) begin
			id_d    = right_id;
			pref_d  = right_pref;
			valid_d = right_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= id_d;
		pref_q <= pref_d;
	end

	assign cell_id    = id_q;
	assign cell_pref  = pref_q;
	assign cell_valid = valid_q;

endmodule

FILE: rtl/two_class_priority_queue.sv
// channel  | handshake            | payload
// ---------+----------------------+---------------------------------
// input    | in_valid / in_stall  | func, id, preferred
// output   | out_valid / out_stall| ok, id_out, class_out, count
//
// one operation per cycle while in_stall is low: every cell compares its id
// with the key at once and the chain shifts right (insert) or left (serve,
// withdraw) in the same cycle. the longest path is the hit ripple along the
// CAPACITY cells. each result appears in an output register in the cycle
// after its transfer; in_stall is high only while that register holds a
// result that is stalled. reset empties the queue and drops any pending result.
module two_class_priority_queue
	import tcpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int ID_BITS  = ID_BITS_DEF,
	localparam int COUNT_W = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [FUNC_W-1:0]  func,
	input  logic [ID_BITS-1:0] id,
	input  logic               preferred,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [ID_BITS-1:0] id_out,
	output logic               class_out,
	output logic [COUNT_W-1:0] count
);

	logic               accept;
	tcpq_ctl_t          ctl;
	logic [ID_BITS-1:0] c_id    [CAPACITY];
	logic               c_pref  [CAPACITY];
	logic               c_valid [CAPACITY];
	logic               c_bound [CAPACITY];
	logic               c_match [CAPACITY];
	logic               hit     [CAPACITY+1];
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] class_vec;
	logic               found;
	logic               found_pref;
	logic               full;
	logic               empty;
	logic               is_insert, is_serve, is_withdraw, is_query, is_size;
	logic               res_ok;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;
	logic               out_valid_q;
	logic               ok_q;
	logic [ID_BITS-1:0] id_out_q;
	logic               class_out_q;
	logic [COUNT_W-1:0] count_out_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign is_insert   = (func == FUNC_INSERT);
	assign is_serve    = (func == FUNC_SERVE);
	assign is_withdraw = (func == FUNC_WITHDRAW);
	assign is_query    = (func == FUNC_QUERY);
	assign is_size     = (func == FUNC_SIZE);

	assign full  = c_valid[CAPACITY-1];
	assign empty = !c_valid[0];

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match_vec[i] = c_match[i];
			class_vec[i] = c_match[i] && c_pref[i];
		end
	end

	assign found      = |match_vec;
	assign found_pref = |class_vec;

	always_comb begin
		ctl.insert   = accept && is_insert && !full && !found;
		ctl.remove   = accept && ((is_serve && !empty) || (is_withdraw && found));
		ctl.serve    = is_serve;
		ctl.ins_pref = preferred;
	end

	assign hit[0] = ctl.serve;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ID_BITS-1:0] l_id, r_id;
		logic               l_pref, l_valid, l_bound, r_pref, r_valid;

		if (i == 0) begin : g_head
			assign l_id    = id;
			assign l_pref  = 1'b0;
			assign l_valid = 1'b0;
			assign l_bound = 1'b0;
		end else begin : g_mid
			assign l_id    = c_id[i-1];
			assign l_pref  = c_pref[i-1];
			assign l_valid = c_valid[i-1];
			assign l_bound = c_bound[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_id    = '0;
			assign r_pref  = 1'b0;
			assign r_valid = 1'b0;
		end else begin : g_body
			assign r_id    = c_id[i+1];
			assign r_pref  = c_pref[i+1];
			assign r_valid = c_valid[i+1];
		end

		tcpq_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (id),
			.left_id    (l_id),
			.left_pref  (l_pref),
			.left_valid (l_valid),
			.left_bound (l_bound),
			.right_id   (r_id),
			.right_pref (r_pref),
			.right_valid(r_valid),
			.hit_in     (hit[i]),
			.cell_id    (c_id[i]),
			.cell_pref  (c_pref[i]),
			.cell_valid (c_valid[i]),
			.bound      (c_bound[i]),
			.hit_out    (hit[i+1]),
			.match      (c_match[i])
		);
	end

	always_comb begin
		count_d = count_q;
		if (ctl.insert) begin
			count_d = count_q + COUNT_W'(1);
		end else if (ctl.remove) begin
			count_d = count_q - COUNT_W'(1);
		end
	end

	assign res_ok = ctl.insert || ctl.remove || (is_query && found) || is_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q        <= res_ok;
			id_out_q    <= (is_serve && !empty) ? c_id[0] : '0;
			class_out_q <= is_query && found_pref;
			count_out_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign id_out    = id_out_q;
	assign class_out = class_out_q;
	assign count     = count_out_q;

endmodule
